>>> design/assert_macros.svh
// Assertion macros shared by the ray/sphere depth RTL.
// Needs signals named clk and rst in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RSND_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define RSND_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define RSND_ASSERT(label, prop)
`define RSND_ASSERT_RST(label, prop)
`endif
`endif

>>> design/rsnd_pkg.sv
// Package for the ray/sphere near depth block: widths, codes, reset values
// and pipeline payload types. No dependencies.
`default_nettype none
package rsnd_pkg;

  localparam int FRAC_BITS = 16;
  localparam int UNIT_BITS = 28;
  localparam int COORD_W   = 32;
  localparam int RADIUS_W  = 31;
  localparam int DIFF_W    = 33;
  localparam int MAG_W     = 32;
  localparam int QUOT_W    = 29;
  localparam int UNIT_W    = 30;
  localparam int SQ_W      = 64;
  localparam int A_W       = 36;
  localparam int CFG_IDX_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Z = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS   = 8'd3;

  localparam logic [1:0] STATUS_HIT  = 2'd0;
  localparam logic [1:0] STATUS_MISS = 2'd1;
  localparam logic [1:0] STATUS_ZERO = 2'd2;

  localparam logic [COORD_W-1:0]  CX_RESET = COORD_W'(12 << FRAC_BITS);
  localparam logic [COORD_W-1:0]  CY_RESET = COORD_W'(6 << FRAC_BITS);
  localparam logic [COORD_W-1:0]  CZ_RESET = COORD_W'(60 << FRAC_BITS);
  localparam logic [RADIUS_W-1:0] R_RESET  = RADIUS_W'(10 << FRAC_BITS);

  // carried alongside the direction length root
  typedef struct packed {
    logic                          zero;
    logic [COORD_W-1:0]            oz;
    logic [2:0][DIFF_W-1:0]        w;
    logic [2:0]                    neg;
    logic [2:0][MAG_W-1:0]         mag;
  } len_pl_t;

  // carried alongside the unit vector divide
  typedef struct packed {
    logic                          zero;
    logic [COORD_W-1:0]            oz;
    logic [2:0][DIFF_W-1:0]        w;
    logic [2:0]                    neg;
  } unit_pl_t;

  // carried alongside the discriminant root
  typedef struct packed {
    logic                          zero;
    logic                          miss;
    logic [COORD_W-1:0]            oz;
    logic [A_W-1:0]                a;
    logic [UNIT_W-1:0]             uz;
  } root_pl_t;

endpackage
`default_nettype wire

>>> design/rsnd_isqrt.sv
// Pipelined integer square root, one result bit per stage, with sideband.
// Standalone; floor(sqrt(x)) of a W-bit unsigned value.
`default_nettype none
module rsnd_isqrt #(
  parameter int W  = 64,
  parameter int PW = 1
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_vld,
  input  logic [W-1:0]    in_x,
  input  logic [PW-1:0]   in_pl,
  output logic            out_vld,
  output logic [W/2-1:0]  out_root,
  output logic [PW-1:0]   out_pl
);
  localparam int N = W / 2;

  logic [W-1:0]  x_q   [N];
  logic [W-1:0]  res_q [N];
  logic          vld_q [N];
  logic [PW-1:0] pl_q  [N];

  for (genvar j = 0; j < N; j++) begin : g_stage
    localparam logic [W-1:0] BIT = W'(1) << (W - 2 - 2 * j);
    logic [W-1:0]  xi, ri;
    logic          vi;
    logic [PW-1:0] pi;
    logic [W:0]    trial;
    logic          take;

    if (j == 0) begin : g_first
      assign xi = in_x;
      assign ri = '0;
      assign vi = in_vld;
      assign pi = in_pl;
    end else begin : g_next
      assign xi = x_q[j-1];
      assign ri = res_q[j-1];
      assign vi = vld_q[j-1];
      assign pi = pl_q[j-1];
    end

    assign trial = {1'b0, ri} + {1'b0, BIT};
    assign take  = {1'b0, xi} >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[j] <= 1'b0;
      end else if (en) begin
        vld_q[j] <= vi;
      end
      if (en) begin
        x_q[j]   <= take ? xi - trial[W-1:0] : xi;
        res_q[j] <= take ? (ri >> 1) + BIT : ri >> 1;
        pl_q[j]  <= pi;
      end
    end
  end

  assign out_vld  = vld_q[N-1];
  assign out_root = res_q[N-1][N-1:0];
  assign out_pl   = pl_q[N-1];
endmodule
`default_nettype wire

>>> design/rsnd_div.sv
// Pipelined restoring divider, several lanes over one shared divisor.
// Computes (num << (QB-1)) / den per lane, num <= den; one quotient bit a stage.
`default_nettype none
module rsnd_div #(
  parameter int DB    = 32,
  parameter int QB    = 29,
  parameter int LANES = 3,
  parameter int PW    = 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_vld,
  input  logic [LANES-1:0][DB-1:0]    in_num,
  input  logic [DB-1:0]               in_den,
  input  logic [PW-1:0]               in_pl,
  output logic                        out_vld,
  output logic [LANES-1:0][QB-1:0]    out_q,
  output logic [PW-1:0]               out_pl
);
  localparam int CW = DB + QB;

  logic [LANES-1:0][CW-1:0] rem_q [QB];
  logic [LANES-1:0][QB-1:0] quo_q [QB];
  logic [DB-1:0]            den_q [QB];
  logic                     vld_q [QB];
  logic [PW-1:0]            pl_q  [QB];

  for (genvar j = 0; j < QB; j++) begin : g_stage
    localparam int B = QB - 1 - j;
    logic [LANES-1:0][CW-1:0] ri;
    logic [LANES-1:0][QB-1:0] qi;
    logic [DB-1:0]            di;
    logic                     vi;
    logic [PW-1:0]            pi;
    logic [CW-1:0]            cand;

    if (j == 0) begin : g_first
      for (genvar l = 0; l < LANES; l++) begin : g_lane
        assign ri[l] = CW'({in_num[l], {(QB-1){1'b0}}});
      end
      assign qi = '0;
      assign di = in_den;
      assign vi = in_vld;
      assign pi = in_pl;
    end else begin : g_next
      assign ri = rem_q[j-1];
      assign qi = quo_q[j-1];
      assign di = den_q[j-1];
      assign vi = vld_q[j-1];
      assign pi = pl_q[j-1];
    end

    assign cand = CW'(di) << B;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[j] <= 1'b0;
      end else if (en) begin
        vld_q[j] <= vi;
      end
      if (en) begin
        for (int l = 0; l < LANES; l++) begin
          if (ri[l] >= cand) begin
            rem_q[j][l] <= ri[l] - cand;
            quo_q[j][l] <= qi[l] | (QB'(1) << B);
          end else begin
            rem_q[j][l] <= ri[l];
            quo_q[j][l] <= qi[l];
          end
        end
        den_q[j] <= di;
        pl_q[j]  <= pi;
      end
    end
  end

  assign out_vld = vld_q[QB-1];
  assign out_q   = quo_q[QB-1];
  assign out_pl  = pl_q[QB-1];
endmodule
`default_nettype wire

>>> design/ray_sphere_near_depth_top.sv
// Ray / sphere near depth, top level: config registers and the full pipeline.
// Uses rsnd_pkg, rsnd_isqrt, rsnd_div and assert_macros.svh.
//
//  channel   | dir | handshake                     | payload (low bits first)
//  ----------+-----+-------------------------------+------------------------------------
//  s_axis    | in  | s_axis_tvalid / s_axis_tready | tdata: origin_x,y,z, dir_x,y,z
//  m_axis    | out | m_axis_tvalid / m_axis_tready | tuser: status; tdata: depth
//  cfg       | in  | cfg_valid / cfg_ready         | cfg_index, cfg_data
//
// One ray per cycle sustained while the output is not stalled; from transfer in to result out a ray
// passes 4 front stages, 32-stage length root, 29-stage unit divide, 8 middle stages,
// 32-stage discriminant root, 3 tail stages. The two square roots and the divider
// set the depth. The whole pipeline advances on one enable: it moves whenever
// the output register is empty or being taken, so a stall freezes every stage.
// Synchronous reset clears all valid bits and loads the sphere defaults.
// Config transfers are always taken; write only with the pipeline drained.
`default_nettype none
`include "assert_macros.svh"
module ray_sphere_near_depth_top
  import rsnd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [191:0]          s_axis_tdata,   // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [31:0]           m_axis_tdata,   // depth
  output logic [1:0]            m_axis_tuser,   // status
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]           cfg_data
);

  // ---------------- configuration ----------------
  logic [COORD_W-1:0]  center [3];
  logic [RADIUS_W-1:0] radius;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      center[0] <= CX_RESET;
      center[1] <= CY_RESET;
      center[2] <= CZ_RESET;
      radius    <= R_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_CENTER_X: center[0] <= cfg_data;
        REG_CENTER_Y: center[1] <= cfg_data;
        REG_CENTER_Z: center[2] <= cfg_data;
        REG_RADIUS:   radius    <= cfg_data[RADIUS_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- global advance ----------------
  logic out_vld;
  logic en;
  assign en            = !out_vld || m_axis_tready;
  assign s_axis_tready = en;

  logic in_vld;
  assign in_vld = s_axis_tvalid;

  // ---------------- stage 1: magnitude, normalize shift, w = c - o ----------------
  logic [COORD_W-1:0] o_in [3];
  logic [COORD_W-1:0] v_in [3];
  logic [MAG_W-1:0]   vmag [3];
  logic [MAG_W-1:0]   mmax;
  logic [4:0]         msb;
  logic [4:0]         kshift;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      o_in[i] = s_axis_tdata[i*COORD_W +: COORD_W];
      v_in[i] = s_axis_tdata[(i+3)*COORD_W +: COORD_W];
      vmag[i] = v_in[i][COORD_W-1] ? -v_in[i] : v_in[i];
    end
    mmax = vmag[0];
    if (vmag[1] > mmax) mmax = vmag[1];
    if (vmag[2] > mmax) mmax = vmag[2];
    msb = '0;
    for (int b = 0; b < MAG_W; b++) begin
      if (mmax[b]) msb = 5'(b);
    end
    kshift = (msb >= 5'd30) ? 5'd0 : 5'd30 - msb;
  end

  logic                s1_vld, s1_zero;
  logic [COORD_W-1:0]  s1_v [3];
  logic [4:0]          s1_k;
  logic [DIFF_W-1:0]   s1_w [3];
  logic [COORD_W-1:0]  s1_oz;

  // ---------------- stage 2: scaled direction n, its sign and magnitude ----------------
  logic                s2_vld, s2_zero;
  logic [MAG_W-1:0]    s2_mag [3];
  logic [2:0]          s2_neg;
  logic [DIFF_W-1:0]   s2_w [3];
  logic [COORD_W-1:0]  s2_oz;
  logic [COORD_W-1:0]  n_sc [3];

  always_comb begin
    for (int i = 0; i < 3; i++) n_sc[i] = s1_v[i] << s1_k;
  end

  // ---------------- stage 3: squares; stage 4: sum ----------------
  logic                s3_vld, s3_zero;
  logic [SQ_W-1:0]     s3_sq [3];
  logic [MAG_W-1:0]    s3_mag [3];
  logic [2:0]          s3_neg;
  logic [DIFF_W-1:0]   s3_w [3];
  logic [COORD_W-1:0]  s3_oz;

  logic                s4_vld;
  logic [SQ_W-1:0]     s4_s2;
  len_pl_t             s4_pl;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
      s3_vld <= 1'b0;
      s4_vld <= 1'b0;
    end else if (en) begin
      s1_vld <= in_vld && s_axis_tready;
      s2_vld <= s1_vld;
      s3_vld <= s2_vld;
      s4_vld <= s3_vld;
    end
    if (en) begin
      s1_zero <= (mmax == '0);
      s1_k    <= kshift;
      s1_oz   <= o_in[2];
      for (int i = 0; i < 3; i++) begin
        s1_v[i] <= v_in[i];
        s1_w[i] <= {center[i][COORD_W-1], center[i]} - {o_in[i][COORD_W-1], o_in[i]};
      end

      s2_zero <= s1_zero;
      s2_oz   <= s1_oz;
      for (int i = 0; i < 3; i++) begin
        s2_neg[i] <= n_sc[i][COORD_W-1];
        s2_mag[i] <= n_sc[i][COORD_W-1] ? -n_sc[i] : n_sc[i];
        s2_w[i]   <= s1_w[i];
      end

      s3_zero <= s2_zero;
      s3_oz   <= s2_oz;
      s3_neg  <= s2_neg;
      for (int i = 0; i < 3; i++) begin
        s3_sq[i]  <= SQ_W'(s2_mag[i]) * SQ_W'(s2_mag[i]);
        s3_mag[i] <= s2_mag[i];
        s3_w[i]   <= s2_w[i];
      end

      s4_s2      <= s3_sq[0] + s3_sq[1] + s3_sq[2];
      s4_pl.zero <= s3_zero;
      s4_pl.oz   <= s3_oz;
      s4_pl.neg  <= s3_neg;
      for (int i = 0; i < 3; i++) begin
        s4_pl.w[i]   <= s3_w[i];
        s4_pl.mag[i] <= s3_mag[i];
      end
    end
  end

  // ---------------- direction length ----------------
  logic               len_vld;
  logic [MAG_W-1:0]   len_root;
  logic [$bits(len_pl_t)-1:0] len_pl_bits;
  len_pl_t            len_pl;

  rsnd_isqrt #(.W(SQ_W), .PW($bits(len_pl_t))) u_len_root (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (s4_vld),
    .in_x     (s4_s2),
    .in_pl    (s4_pl),
    .out_vld  (len_vld),
    .out_root (len_root),
    .out_pl   (len_pl_bits)
  );
  assign len_pl = len_pl_t'(len_pl_bits);

  // ---------------- unit vector magnitudes, Q1.28 ----------------
  logic                        dv_vld;
  logic [2:0][QUOT_W-1:0]      dv_q;
  logic [$bits(unit_pl_t)-1:0] dv_pl_bits;
  unit_pl_t                    dv_in_pl, dv_pl;

  assign dv_in_pl.zero = len_pl.zero;
  assign dv_in_pl.oz   = len_pl.oz;
  assign dv_in_pl.w    = len_pl.w;
  assign dv_in_pl.neg  = len_pl.neg;

  rsnd_div #(.DB(MAG_W), .QB(QUOT_W), .LANES(3), .PW($bits(unit_pl_t))) u_unit_div (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (len_vld),
    .in_num  (len_pl.mag),
    .in_den  (len_root),
    .in_pl   (dv_in_pl),
    .out_vld (dv_vld),
    .out_q   (dv_q),
    .out_pl  (dv_pl_bits)
  );
  assign dv_pl = unit_pl_t'(dv_pl_bits);

  // ---------------- middle stages: a, perpendicular offset, discriminant ----------------
  logic                       s5_vld, s5_zero;
  logic signed [UNIT_W-1:0]   s5_u [3];
  logic signed [DIFF_W-1:0]   s5_w [3];
  logic [COORD_W-1:0]         s5_oz;

  logic                       s6_vld, s6_zero;
  logic signed [62:0]         s6_prod [3];
  logic signed [UNIT_W-1:0]   s6_u [3];
  logic signed [DIFF_W-1:0]   s6_w [3];
  logic [COORD_W-1:0]         s6_oz;

  logic                       s7_vld, s7_zero;
  logic signed [A_W-1:0]      s7_a;
  logic signed [UNIT_W-1:0]   s7_u [3];
  logic signed [DIFF_W-1:0]   s7_w [3];
  logic [COORD_W-1:0]         s7_oz;
  logic signed [63:0]         dot;

  logic                       s8_vld, s8_zero;
  logic signed [65:0]         s8_au [3];
  logic signed [A_W-1:0]      s8_a;
  logic signed [UNIT_W-1:0]   s8_uz;
  logic signed [DIFF_W-1:0]   s8_w [3];
  logic [COORD_W-1:0]         s8_oz;

  logic signed [38:0]         perp [3];
  logic [38:0]                pmag [3];
  logic                       far_any;

  logic                       s9_vld, s9_zero, s9_far;
  logic [RADIUS_W-1:0]        s9_pm [3];
  logic signed [A_W-1:0]      s9_a;
  logic signed [UNIT_W-1:0]   s9_uz;
  logic [COORD_W-1:0]         s9_oz;

  logic                       s10_vld, s10_zero, s10_far;
  logic [61:0]                s10_psq [3];
  logic [61:0]                s10_r2;
  logic signed [A_W-1:0]      s10_a;
  logic signed [UNIT_W-1:0]   s10_uz;
  logic [COORD_W-1:0]         s10_oz;

  logic                       s11_vld, s11_zero, s11_far;
  logic [SQ_W-1:0]            s11_p2;
  logic [61:0]                s11_r2;
  logic signed [A_W-1:0]      s11_a;
  logic signed [UNIT_W-1:0]   s11_uz;
  logic [COORD_W-1:0]         s11_oz;

  logic                       s12_vld;
  logic [SQ_W-1:0]            s12_disc;
  root_pl_t                   s12_pl;

  always_comb begin
    dot = {s6_prod[0][62], s6_prod[0]} + {s6_prod[1][62], s6_prod[1]}
        + {s6_prod[2][62], s6_prod[2]};
    far_any = 1'b0;
    for (int i = 0; i < 3; i++) begin
      perp[i] = {{6{s8_w[i][DIFF_W-1]}}, s8_w[i]} - {s8_au[i][65], s8_au[i][65:28]};
      pmag[i] = perp[i][38] ? -perp[i] : perp[i];
      if (pmag[i] > {8'b0, radius}) far_any = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_vld  <= 1'b0;
      s6_vld  <= 1'b0;
      s7_vld  <= 1'b0;
      s8_vld  <= 1'b0;
      s9_vld  <= 1'b0;
      s10_vld <= 1'b0;
      s11_vld <= 1'b0;
      s12_vld <= 1'b0;
    end else if (en) begin
      s5_vld  <= dv_vld;
      s6_vld  <= s5_vld;
      s7_vld  <= s6_vld;
      s8_vld  <= s7_vld;
      s9_vld  <= s8_vld;
      s10_vld <= s9_vld;
      s11_vld <= s10_vld;
      s12_vld <= s11_vld;
    end
    if (en) begin
      // signed unit vector
      s5_zero <= dv_pl.zero;
      s5_oz   <= dv_pl.oz;
      for (int i = 0; i < 3; i++) begin
        s5_u[i] <= dv_pl.neg[i] ? -$signed({1'b0, dv_q[i]}) : $signed({1'b0, dv_q[i]});
        s5_w[i] <= $signed(dv_pl.w[i]);
      end

      // w_i * u_i
      s6_zero <= s5_zero;
      s6_oz   <= s5_oz;
      for (int i = 0; i < 3; i++) begin
        s6_prod[i] <= s5_w[i] * s5_u[i];
        s6_u[i]    <= s5_u[i];
        s6_w[i]    <= s5_w[i];
      end

      // a = floor(dot / 2^28)
      s7_zero <= s6_zero;
      s7_oz   <= s6_oz;
      s7_a    <= dot[63:UNIT_BITS];
      for (int i = 0; i < 3; i++) begin
        s7_u[i] <= s6_u[i];
        s7_w[i] <= s6_w[i];
      end

      // a * u_i
      s8_zero <= s7_zero;
      s8_oz   <= s7_oz;
      s8_a    <= s7_a;
      s8_uz   <= s7_u[2];
      for (int i = 0; i < 3; i++) begin
        s8_au[i] <= s7_a * s7_u[i];
        s8_w[i]  <= s7_w[i];
      end

      // perpendicular offset and far test
      s9_zero <= s8_zero;
      s9_oz   <= s8_oz;
      s9_a    <= s8_a;
      s9_uz   <= s8_uz;
      s9_far  <= far_any;
      for (int i = 0; i < 3; i++) s9_pm[i] <= pmag[i][RADIUS_W-1:0];

      // squares of offset and radius
      s10_zero <= s9_zero;
      s10_oz   <= s9_oz;
      s10_a    <= s9_a;
      s10_uz   <= s9_uz;
      s10_far  <= s9_far;
      s10_r2   <= 62'(radius) * 62'(radius);
      for (int i = 0; i < 3; i++) s10_psq[i] <= 62'(s9_pm[i]) * 62'(s9_pm[i]);

      // |p|^2
      s11_zero <= s10_zero;
      s11_oz   <= s10_oz;
      s11_a    <= s10_a;
      s11_uz   <= s10_uz;
      s11_far  <= s10_far;
      s11_r2   <= s10_r2;
      s11_p2   <= SQ_W'(s10_psq[0]) + SQ_W'(s10_psq[1]) + SQ_W'(s10_psq[2]);

      // miss decision and discriminant
      s12_disc    <= SQ_W'(s11_r2) - s11_p2;
      s12_pl.zero <= s11_zero;
      s12_pl.miss <= s11_far || (s11_p2 > SQ_W'(s11_r2));
      s12_pl.oz   <= s11_oz;
      s12_pl.a    <= s11_a;
      s12_pl.uz   <= s11_uz;
    end
  end

  // ---------------- discriminant root ----------------
  logic                        rt_vld;
  logic [31:0]                 rt_root;
  logic [$bits(root_pl_t)-1:0] rt_pl_bits;
  root_pl_t                    rt_pl;

  rsnd_isqrt #(.W(SQ_W), .PW($bits(root_pl_t))) u_disc_root (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (s12_vld),
    .in_x     (s12_disc),
    .in_pl    (s12_pl),
    .out_vld  (rt_vld),
    .out_root (rt_root),
    .out_pl   (rt_pl_bits)
  );
  assign rt_pl = root_pl_t'(rt_pl_bits);

  // ---------------- tail: t, t*u_z, depth with saturation ----------------
  logic                       s13_vld, s13_zero, s13_miss;
  logic signed [36:0]         s13_t;
  logic signed [UNIT_W-1:0]   s13_uz;
  logic [COORD_W-1:0]         s13_oz;

  logic                       s14_vld, s14_zero, s14_miss;
  logic signed [66:0]         s14_tu;
  logic [COORD_W-1:0]         s14_oz;

  logic signed [39:0]         dz;
  logic [COORD_W-1:0]         dz_sat;
  logic [1:0]                 out_status;
  logic [COORD_W-1:0]         out_depth;

  always_comb begin
    dz = {{8{s14_oz[COORD_W-1]}}, s14_oz} + {s14_tu[66], s14_tu[66:UNIT_BITS]};
    if (dz > 40'sh007FFFFFFF) begin
      dz_sat = 32'h7FFFFFFF;
    end else if (dz < -40'sh0080000000) begin
      dz_sat = 32'h80000000;
    end else begin
      dz_sat = dz[COORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s13_vld <= 1'b0;
      s14_vld <= 1'b0;
      out_vld <= 1'b0;
    end else if (en) begin
      s13_vld <= rt_vld;
      s14_vld <= s13_vld;
      out_vld <= s14_vld;
    end
    if (en) begin
      s13_zero <= rt_pl.zero;
      s13_miss <= rt_pl.miss;
      s13_oz   <= rt_pl.oz;
      s13_uz   <= $signed(rt_pl.uz);
      s13_t    <= {rt_pl.a[A_W-1], rt_pl.a} - $signed({5'b0, rt_root});

      s14_zero <= s13_zero;
      s14_miss <= s13_miss;
      s14_oz   <= s13_oz;
      s14_tu   <= s13_t * s13_uz;

      if (s14_zero) begin
        out_status <= STATUS_ZERO;
        out_depth  <= '0;
      end else if (s14_miss) begin
        out_status <= STATUS_MISS;
        out_depth  <= '0;
      end else begin
        out_status <= STATUS_HIT;
        out_depth  <= dz_sat;
      end
    end
  end

  assign m_axis_tvalid = out_vld;
  assign m_axis_tuser  = out_status;
  assign m_axis_tdata  = out_depth;

  // ---------------- checks ----------------
  `RSND_ASSERT(a_nohit_depth_zero, m_axis_tvalid && m_axis_tuser != STATUS_HIT |-> m_axis_tdata == '0)
  `RSND_ASSERT(a_status_code, m_axis_tvalid |-> (m_axis_tuser == STATUS_HIT || m_axis_tuser == STATUS_MISS || m_axis_tuser == STATUS_ZERO))
  `RSND_ASSERT(a_ready_follows_out, s_axis_tready == (!m_axis_tvalid || m_axis_tready))
  `RSND_ASSERT_RST(a_reset_empty, rst |=> !m_axis_tvalid)

endmodule
`default_nettype wire
